@@ hw/rtl/i80_pkg.sv @@
// ----------------------------------------------------------------------------
// i80_pkg
// Shared types and constants for the 8080-style bus write controller.
// ----------------------------------------------------------------------------
package i80_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ASSERT  = 3'd1,
        PH_RELEASE = 3'd2,
        PH_TAIL    = 3'd3,
        PH_SETTLE  = 3'd4
    } i80_phase_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ASSERT_POLL_LIMIT  = 2'd0,
        REG_RELEASE_POLL_LIMIT = 2'd1,
        REG_RELEASE_POLL_TICKS = 2'd2,
        REG_SETTLE_TICKS       = 2'd3
    } i80_reg_idx_t;

    // input kind codes
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [7:0] ASSERT_POLL_LIMIT_RST  = 8'd20;
    localparam logic [7:0] RELEASE_POLL_LIMIT_RST = 8'd200;
    localparam logic [3:0] RELEASE_POLL_TICKS_RST = 4'd10;
    localparam logic [3:0] SETTLE_TICKS_RST       = 4'd5;

    typedef struct packed {
        logic [7:0] assert_poll_limit;
        logic [7:0] release_poll_limit;
        logic [3:0] release_poll_ticks;
        logic [3:0] settle_ticks;
    } i80_cfg_t;

    typedef struct packed {
        i80_phase_t phase;
        logic [7:0] polls_left;
        logic [3:0] interval_count;
        logic       held_a0;
        logic [7:0] held_data;
    } i80_state_t;

    typedef struct packed {
        logic write_strobe;
        logic chip_select;
        logic done_res;
        logic assert_timeout;
        logic release_timeout;
        logic rejected;
    } i80_flags_t;

endpackage

@@ hw/rtl/i80_step.sv @@
// ----------------------------------------------------------------------------
// i80_step
// Next-state and result flag logic for one accepted transaction.
// ----------------------------------------------------------------------------
module i80_step import i80_pkg::*; (
    input  i80_cfg_t   cfg,
    input  i80_state_t cur,
    input  logic       kind,
    input  logic       command_flag,
    input  logic [7:0] write_byte,
    input  logic       busy_pin,
    output i80_state_t nxt,
    output i80_flags_t flags
);

    logic [7:0] assert_limit_eff;
    logic [7:0] release_limit_eff;
    logic [3:0] reload_ticks;
    logic [7:0] polls_dec;
    logic [3:0] interval_dec;
    logic       is_idle;

    assign assert_limit_eff  = (cfg.assert_poll_limit == 8'd0) ? 8'd1 : cfg.assert_poll_limit;
    assign release_limit_eff = (cfg.release_poll_limit == 8'd0) ? 8'd1
                                                                 : cfg.release_poll_limit;
    // interval reload, zero interval acts as one tick
    assign reload_ticks = (cfg.release_poll_ticks == 4'd0) ? 4'd0
                                                           : cfg.release_poll_ticks - 4'd1;
    assign polls_dec    = cur.polls_left - 8'd1;
    assign interval_dec = cur.interval_count - 4'd1;
    assign is_idle      = (cur.phase == PH_IDLE);

    // next state
    always_comb begin
        nxt = cur;
        if (kind == KIND_WRITE) begin
            if (is_idle) begin
                nxt.held_a0        = command_flag;
                nxt.held_data      = write_byte;
                nxt.phase          = PH_ASSERT;
                nxt.polls_left     = assert_limit_eff;
                nxt.interval_count = 4'd0;
            end
        end else begin
            unique case (cur.phase)
                PH_IDLE: begin
                end
                PH_ASSERT: begin
                    nxt.polls_left = polls_dec;
                    if (busy_pin || polls_dec == 8'd0) begin
                        nxt.phase          = PH_RELEASE;
                        nxt.polls_left     = release_limit_eff;
                        nxt.interval_count = 4'd0;
                    end
                end
                PH_RELEASE: begin
                    if (cur.interval_count != 4'd0) begin
                        nxt.interval_count = interval_dec;
                    end else begin
                        nxt.polls_left     = polls_dec;
                        nxt.interval_count = reload_ticks;
                        if (!busy_pin || polls_dec == 8'd0) begin
                            if (reload_ticks != 4'd0) begin
                                nxt.phase = PH_TAIL;
                            end else if (cfg.settle_ticks == 4'd0) begin
                                nxt.phase          = PH_IDLE;
                                nxt.interval_count = 4'd0;
                            end else begin
                                nxt.phase          = PH_SETTLE;
                                nxt.interval_count = cfg.settle_ticks;
                            end
                        end
                    end
                end
                PH_TAIL: begin
                    nxt.interval_count = interval_dec;
                    if (interval_dec == 4'd0) begin
                        if (cfg.settle_ticks == 4'd0) begin
                            nxt.phase = PH_IDLE;
                        end else begin
                            nxt.phase          = PH_SETTLE;
                            nxt.interval_count = cfg.settle_ticks;
                        end
                    end
                end
                PH_SETTLE: begin
                    nxt.interval_count = interval_dec;
                    if (interval_dec == 4'd0) begin
                        nxt.phase = PH_IDLE;
                    end
                end
                default: begin
                    nxt.phase          = PH_IDLE;
                    nxt.interval_count = 4'd0;
                end
            endcase
        end
    end

    // result flags
    always_comb begin
        flags = '0;
        if (kind == KIND_WRITE) begin
            flags.chip_select  = 1'b1;
            flags.write_strobe = is_idle;
            flags.rejected     = !is_idle;
        end else begin
            flags.chip_select = !is_idle;
            unique case (cur.phase)
                PH_IDLE: begin
                end
                PH_ASSERT: begin
                    flags.assert_timeout = (polls_dec == 8'd0);
                end
                PH_RELEASE: begin
                    if (cur.interval_count == 4'd0) begin
                        flags.release_timeout = (polls_dec == 8'd0);
                        flags.done_res = (!busy_pin || polls_dec == 8'd0)
                                         && reload_ticks == 4'd0
                                         && cfg.settle_ticks == 4'd0;
                    end
                end
                PH_TAIL: begin
                    flags.done_res = (interval_dec == 4'd0) && (cfg.settle_ticks == 4'd0);
                end
                PH_SETTLE: begin
                    flags.done_res = (interval_dec == 4'd0);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/i80_bus_write_busy_handshake.sv @@
// ----------------------------------------------------------------------------
// i80_bus_write_busy_handshake
// Write controller for an 8080-style display bus with busy-pin handshake.
// ----------------------------------------------------------------------------
// Each transaction on the input stream is either a write request or a one
// microsecond tick (tuser). A write taken while idle latches A0 and the data
// byte and pulses the write strobe; each following tick polls busy, first
// until it reads high, then once per release interval until it reads low,
// then waits out the rest of that interval, counts the settle ticks and
// raises done. Every input transaction gives exactly one result transaction.
// The block takes one transaction per clock: the state update and result
// flags are one level of logic into the result register, and a new input is
// taken whenever the result register is empty or being drained in the same cycle.
module i80_bus_write_busy_handshake import i80_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command_flag, write_byte[7:0], busy_pin, zero pad
    input  logic        s_tuser,   // kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // bus_a0, bus_data[7:0], write_strobe, chip_select,
                                   // done_res, assert_timeout, release_timeout,
                                   // rejected, zero pad
);

    i80_cfg_t    cfg_reg;
    i80_state_t  state_reg;
    i80_state_t  state_next;
    i80_flags_t  flags;
    logic        m_tvalid_reg;
    logic [14:0] m_data_reg;
    logic        s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    i80_step u_step (
        .cfg          (cfg_reg),
        .cur          (state_reg),
        .kind         (s_tuser),
        .command_flag (s_tdata[0]),
        .write_byte   (s_tdata[8:1]),
        .busy_pin     (s_tdata[9]),
        .nxt          (state_next),
        .flags        (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.assert_poll_limit  <= ASSERT_POLL_LIMIT_RST;
            cfg_reg.release_poll_limit <= RELEASE_POLL_LIMIT_RST;
            cfg_reg.release_poll_ticks <= RELEASE_POLL_TICKS_RST;
            cfg_reg.settle_ticks       <= SETTLE_TICKS_RST;
        end else if (cfg_we) begin
            unique case (i80_reg_idx_t'(cfg_index))
                REG_ASSERT_POLL_LIMIT:  cfg_reg.assert_poll_limit  <= cfg_data;
                REG_RELEASE_POLL_LIMIT: cfg_reg.release_poll_limit <= cfg_data;
                REG_RELEASE_POLL_TICKS: cfg_reg.release_poll_ticks <= cfg_data[3:0];
                REG_SETTLE_TICKS:       cfg_reg.settle_ticks       <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '{phase: PH_IDLE, default: '0};
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {flags.rejected, flags.release_timeout, flags.assert_timeout,
                           flags.done_res, flags.chip_select, flags.write_strobe,
                           state_next.held_data, state_next.held_a0};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

    // a write accepted while idle starts a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == KIND_WRITE && state_reg.phase == PH_IDLE)
        |=> (state_reg.phase == PH_ASSERT))
        else $error("write from idle did not enter assert phase");

    // without an accepted transaction the state holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(state_reg))
        else $error("state changed without an accepted transaction");

    // done always comes with chip select
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_data_reg[11]) |-> m_data_reg[10])
        else $error("done raised without chip select");

    // a pending result that is not taken stays valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg && $stable(m_data_reg))
        else $error("stalled result lost");

    // reset leaves the block idle with no result pending
    assert property (@(posedge aclk)
        !aresetn |=> (state_reg.phase == PH_IDLE) && !m_tvalid_reg)
        else $error("block not idle after reset");

endmodule

@@ tb/i80_write_sb_pkg.sv @@
// ----------------------------------------------------------------------------
// i80_write_sb_pkg
// Result predictor and scoreboard for the 8080-style bus write controller.
// Keeps its own copy of the registers and transaction state, works out the
// result of every accepted input transaction and checks the results in order.
// ----------------------------------------------------------------------------
package i80_write_sb_pkg;
    import i80_pkg::*;

    // s_tdata layout, lowest bit first: command_flag, write_byte, busy_pin, pad
    typedef struct packed {
        logic [5:0] pad;
        logic       busy_pin;
        logic [7:0] write_byte;
        logic       command_flag;
    } bus_item_t;

    // m_tdata layout, lowest bit first: bus_a0, bus_data, strobe, cs, done,
    // assert timeout, release timeout, rejected, pad
    typedef struct packed {
        logic       pad;
        logic       rejected;
        logic       release_timeout;
        logic       assert_timeout;
        logic       done_res;
        logic       chip_select;
        logic       write_strobe;
        logic [7:0] bus_data;
        logic       bus_a0;
    } bus_result_t;

    class bus_write_scoreboard;
        i80_cfg_t    cfg;
        i80_phase_t  phase;
        logic [7:0]  polls_left;
        logic [3:0]  interval_cnt;
        logic        sampled_busy;
        logic        held_a0;
        logic [7:0]  held_data;
        bus_result_t expected_q[$];
        int          errors;

        function new();
            cfg.assert_poll_limit  = ASSERT_POLL_LIMIT_RST;
            cfg.release_poll_limit = RELEASE_POLL_LIMIT_RST;
            cfg.release_poll_ticks = RELEASE_POLL_TICKS_RST;
            cfg.settle_ticks       = SETTLE_TICKS_RST;
            phase        = PH_IDLE;
            polls_left   = '0;
            interval_cnt = '0;
            sampled_busy = 1'b0;
            held_a0      = 1'b0;
            held_data    = '0;
            errors       = 0;
        endfunction

        function void write_reg(i80_reg_idx_t idx, logic [7:0] value);
            case (idx)
                REG_ASSERT_POLL_LIMIT:  cfg.assert_poll_limit  = value;
                REG_RELEASE_POLL_LIMIT: cfg.release_poll_limit = value;
                REG_RELEASE_POLL_TICKS: cfg.release_poll_ticks = value[3:0];
                REG_SETTLE_TICKS:       cfg.settle_ticks       = value[3:0];
                default: ;
            endcase
        endfunction

        // returns 1 when done falls on this tick (no settle time)
        function bit start_settle();
            if (cfg.settle_ticks == 4'd0) begin
                phase = PH_IDLE;
                interval_cnt = 4'd0;
                return 1'b1;
            end
            phase = PH_SETTLE;
            interval_cnt = cfg.settle_ticks;
            return 1'b0;
        endfunction

        function void note_item(logic kind, bus_item_t item);
            bus_result_t res;
            logic [3:0]  ticks;
            res = '0;
            ticks = (cfg.release_poll_ticks == 4'd0) ? 4'd1 : cfg.release_poll_ticks;
            if (kind == KIND_WRITE) begin
                res.chip_select = 1'b1;
                if (phase == PH_IDLE) begin
                    held_a0 = item.command_flag;
                    held_data = item.write_byte;
                    res.write_strobe = 1'b1;
                    phase = PH_ASSERT;
                    polls_left = (cfg.assert_poll_limit == 8'd0) ? 8'd1 : cfg.assert_poll_limit;
                    interval_cnt = 4'd0;
                end else begin
                    res.rejected = 1'b1;
                end
            end else if (phase != PH_IDLE) begin
                res.chip_select = 1'b1;
                case (phase)
                    PH_ASSERT: begin
                        sampled_busy = item.busy_pin;
                        polls_left = polls_left - 8'd1;
                        if (polls_left == 8'd0)
                            res.assert_timeout = 1'b1;
                        if (item.busy_pin || polls_left == 8'd0) begin
                            phase = PH_RELEASE;
                            polls_left = (cfg.release_poll_limit == 8'd0) ? 8'd1
                                                                        : cfg.release_poll_limit;
                            interval_cnt = 4'd0;
                        end
                    end
                    PH_RELEASE: begin
                        if (interval_cnt != 4'd0) begin
                            interval_cnt = interval_cnt - 4'd1;
                        end else begin
                            sampled_busy = item.busy_pin;
                            polls_left = polls_left - 8'd1;
                            interval_cnt = ticks - 4'd1;
                            if (polls_left == 8'd0)
                                res.release_timeout = 1'b1;
                            if (!item.busy_pin || polls_left == 8'd0) begin
                                if (interval_cnt == 4'd0)
                                    res.done_res = start_settle();
                                else
                                    phase = PH_TAIL;
                            end
                        end
                    end
                    PH_TAIL: begin
                        interval_cnt = interval_cnt - 4'd1;
                        if (interval_cnt == 4'd0)
                            res.done_res = start_settle();
                    end
                    PH_SETTLE: begin
                        interval_cnt = interval_cnt - 4'd1;
                        if (interval_cnt == 4'd0) begin
                            phase = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                    end
                    default: begin
                        phase = PH_IDLE;
                        interval_cnt = 4'd0;
                    end
                endcase
            end
            res.bus_a0 = held_a0;
            res.bus_data = held_data;
            expected_q.push_back(res);
        endfunction

        function string show(bus_result_t r);
            return $sformatf("a0=%0b data=%02h wr=%0b cs=%0b done=%0b ato=%0b rto=%0b rej=%0b pad=%0b",
                             r.bus_a0, r.bus_data, r.write_strobe, r.chip_select, r.done_res,
                             r.assert_timeout, r.release_timeout, r.rejected, r.pad);
        endfunction

        function void check_result(bus_result_t got);
            bus_result_t exp;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing pending: %s", $time, show(got));
                return;
            end
            exp = expected_q.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: result mismatch", $time);
                    $display("    expected %s", show(exp));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the 8080-style bus write controller with busy handshake.
// Drives write and tick transactions with random gaps on both streams, runs
// directed corner cases and randomized busy-pin waveforms over several
// register settings, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module tb;
    import i80_pkg::*;
    import i80_write_sb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    bus_write_scoreboard sb = new();

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_hold_cycles = 0;
    int items_sent = 0;
    int cycle_count = 0;

    i80_bus_write_busy_handshake DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off when requested
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rx_quiet ? 0 : $urandom_range(0, 7);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata);
        end
    end

    task automatic send_item(logic kind, logic cmd, logic [7:0] wbyte, logic busy);
        int        gap;
        bus_item_t item;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        item = '0;
        item.command_flag = cmd;
        item.write_byte = wbyte;
        item.busy_pin = busy;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= item;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_item(kind, item);
        items_sent++;
    endtask

    // one write transaction; busy reads high for ticks rise .. rise+hold-1
    task automatic run_write(logic cmd, logic [7:0] wbyte, int rise, int hold, bit noisy);
        int   t;
        logic busy;
        t = 0;
        send_item(KIND_WRITE, cmd, wbyte, 1'($urandom_range(0, 1)));
        while (sb.phase != PH_IDLE) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                // write during a transaction gets rejected
                send_item(KIND_WRITE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else begin
                busy = (t >= rise) && (t < rise + hold);
                if (noisy && $urandom_range(0, 9) == 0)
                    busy = ~busy;
                send_item(KIND_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          busy);
                t++;
            end
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_config(logic [7:0] a_lim, logic [7:0] r_lim, logic [3:0] r_ticks,
                               logic [3:0] settle);
        wait_results_drained();
        cfg_we <= 1'b1;
        cfg_index <= REG_ASSERT_POLL_LIMIT;
        cfg_data <= a_lim;
        @(posedge aclk);
        sb.write_reg(REG_ASSERT_POLL_LIMIT, a_lim);
        cfg_index <= REG_RELEASE_POLL_LIMIT;
        cfg_data <= r_lim;
        @(posedge aclk);
        sb.write_reg(REG_RELEASE_POLL_LIMIT, r_lim);
        cfg_index <= REG_RELEASE_POLL_TICKS;
        cfg_data <= {4'd0, r_ticks};
        @(posedge aclk);
        sb.write_reg(REG_RELEASE_POLL_TICKS, {4'd0, r_ticks});
        cfg_index <= REG_SETTLE_TICKS;
        cfg_data <= {4'd0, settle};
        @(posedge aclk);
        sb.write_reg(REG_SETTLE_TICKS, {4'd0, settle});
        cfg_we <= 1'b0;
    endtask

    initial begin
        int a_lim;
        int r_lim;
        int r_ticks;
        int settle;
        int phase_end;
        int rise_max;
        int hold_max;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_ASSERT_POLL_LIMIT;
        cfg_data <= 8'd0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= KIND_TICK;
        m_tready <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values; tick while idle does nothing
        send_item(KIND_TICK, 1'b1, 8'hFF, 1'b1);
        run_write(1'b1, 8'hA5, 3, 12, 1'b0);

        load_config(8'd2, 8'd2, 4'd1, 4'd0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_WRITE, 1'b1, 8'hFF, 1'b0);
        send_item(KIND_WRITE, 1'b0, 8'h00, 1'b1);   // rejected, held values kept
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b1);
        send_item(KIND_TICK, 1'b1, 8'hFF, 1'b0);    // done on the release poll
        // both phases run out of polls
        send_item(KIND_WRITE, 1'b0, 8'h00, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b1);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b1);
        // last poll sees the awaited level and still times out
        send_item(KIND_WRITE, 1'b1, 8'h5A, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b1);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b1);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);

        // zero limits and interval act as one
        load_config(8'd0, 8'd0, 4'd0, 4'd0);
        send_item(KIND_WRITE, 1'b0, 8'h81, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        send_item(KIND_TICK, 1'b0, 8'h00, 1'b1);

        for (int p = 0; p < 12; p++) begin
            case (p)
                0:       begin a_lim = 255; r_lim = 255; r_ticks = 1;  settle = 15; end
                1:       begin a_lim = 1;   r_lim = 1;   r_ticks = 1;  settle = 0;  end
                5:       begin a_lim = 255; r_lim = 1;   r_ticks = 15; settle = 0;  end
                7:       begin a_lim = 20;  r_lim = 200; r_ticks = 10; settle = 5;  end
                default: begin
                    a_lim = $urandom_range(1, 6);
                    r_lim = $urandom_range(1, 6);
                    r_ticks = $urandom_range(1, 4);
                    settle = $urandom_range(0, 4);
                end
            endcase
            load_config(8'(a_lim), 8'(r_lim), 4'(r_ticks), 4'(settle));
            tx_quiet = (p % 4 == 3);
            rx_quiet = (p % 4 == 3);
            if (p == 0) begin
                // full assert wait, then full release wait, at the largest poll limits
                run_write(1'b1, 8'h3C, 300, 0, 1'b0);
                run_write(1'b0, 8'hC3, 0, 5000, 1'b0);
            end
            // receiver stalls long while the sender keeps offering items
            if (p == 6)
                rx_hold_cycles = 300;
            rise_max = (a_lim + 1 > 30) ? 30 : a_lim + 1;
            hold_max = ((r_lim + 1) * r_ticks > 40) ? 40 : (r_lim + 1) * r_ticks;
            phase_end = items_sent + 50;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 5) == 0)
                    send_item(KIND_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                run_write(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          $urandom_range(0, rise_max), $urandom_range(0, hold_max),
                          $urandom_range(0, 3) != 0);
                if (p == 8 && items_sent > phase_end - 40 && items_sent < phase_end - 25)
                    wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/i80_pkg.sv
hw/rtl/i80_step.sv
hw/rtl/i80_bus_write_busy_handshake.sv
tb/i80_write_sb_pkg.sv
tb/tb.sv
